/* hw/rtl/solar_differential_pump_control_defines.svh */
// Assertion helpers for the solar differential pump controller.
`ifndef SOLAR_DIFFERENTIAL_PUMP_CONTROL_DEFINES_SVH
`define SOLAR_DIFFERENTIAL_PUMP_CONTROL_DEFINES_SVH

`define SDPC_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define SDPC_ASSERT(lbl, prop, msg) \
  `SDPC_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

/* hw/rtl/sdpc_pkg.sv */
package sdpc_pkg;

  localparam int unsigned TempW     = 12;
  localparam int unsigned DiffW     = 11;
  localparam int unsigned MinutesW  = 11;
  localparam int unsigned SecondsW  = 12;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned CfgDataW  = 12;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned IntervalW = 27;
  localparam int unsigned DurationW = 22;

  localparam int unsigned MS_PER_MIN = 60000;
  localparam int unsigned MS_PER_S   = 1000;

  localparam logic signed [TempW-1:0] DISCONNECTED_CODE = -12'sd2032;

  localparam logic [CfgIdxW-1:0] REG_MIN_AIR_TEMP       = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_SPA_TEMP       = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_DIFF_THRESHOLD     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_HYSTERESIS         = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_FLUSH_INTERVAL_MIN = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_FLUSH_DURATION_S   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_MANUAL_MODE        = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_MANUAL_PUMP        = 3'd7;

  localparam logic signed [TempW-1:0] MIN_AIR_TEMP_RST   = 12'sd160;
  localparam logic signed [TempW-1:0] MAX_SPA_TEMP_RST   = 12'sd608;
  localparam logic [DiffW-1:0]        DIFF_THRESHOLD_RST = 11'd64;
  localparam logic [DiffW-1:0]        HYSTERESIS_RST     = 11'd16;
  localparam logic [DurationW-1:0]    FLUSH_DURATION_RST = 22'd60000;

  // Disconnected probe reads as zero.
  function automatic logic signed [TempW-1:0] reading(input logic [TempW-1:0] raw);
    logic signed [TempW-1:0] v;
    v = signed'(raw);
    return (v == DISCONNECTED_CODE) ? '0 : v;
  endfunction

endpackage

/* hw/rtl/solar_differential_pump_control.sv */
// Differential thermostat for a solar spa heater: one transaction per cycle in and out
// while out_stall_i is low. A transaction passes an input register and a result register.
// The whole decision, including the update of pump and flush state, sits in one stage
// between the two, so each transaction sees the state left by the one before.
// Flush interval and duration are scaled to milliseconds when written.

`include "solar_differential_pump_control_defines.svh"

module solar_differential_pump_control (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [sdpc_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [sdpc_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [sdpc_pkg::TempW-1:0]    air_temp_i,
  input  logic signed [sdpc_pkg::TempW-1:0]    spa_temp_i,
  input  logic signed [sdpc_pkg::TempW-1:0]    panel_temp_i,
  input  logic [sdpc_pkg::TimeW-1:0]           now_ms_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 pump_on_o,
  output logic                                 pump_changed_o,
  output logic                                 flushing_o,
  output logic                                 safety_cut_o
);

  localparam int unsigned TW = sdpc_pkg::TempW;
  localparam int unsigned NW = sdpc_pkg::TimeW;

  // configuration
  logic signed [TW-1:0]                  min_air_q, max_spa_q;
  logic [sdpc_pkg::DiffW-1:0]            thr_q, hys_q;
  logic [sdpc_pkg::IntervalW-1:0]        interval_ms_q;
  logic [sdpc_pkg::DurationW-1:0]        duration_ms_q;
  logic                                  manual_mode_q, manual_pump_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_air_q     <= sdpc_pkg::MIN_AIR_TEMP_RST;
      max_spa_q     <= sdpc_pkg::MAX_SPA_TEMP_RST;
      thr_q         <= sdpc_pkg::DIFF_THRESHOLD_RST;
      hys_q         <= sdpc_pkg::HYSTERESIS_RST;
      interval_ms_q <= '0;
      duration_ms_q <= sdpc_pkg::FLUSH_DURATION_RST;
      manual_mode_q <= 1'b0;
      manual_pump_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sdpc_pkg::REG_MIN_AIR_TEMP:   min_air_q <= signed'(cfg_data_i[TW-1:0]);
        sdpc_pkg::REG_MAX_SPA_TEMP:   max_spa_q <= signed'(cfg_data_i[TW-1:0]);
        sdpc_pkg::REG_DIFF_THRESHOLD: thr_q <= cfg_data_i[sdpc_pkg::DiffW-1:0];
        sdpc_pkg::REG_HYSTERESIS:     hys_q <= cfg_data_i[sdpc_pkg::DiffW-1:0];
        sdpc_pkg::REG_FLUSH_INTERVAL_MIN: begin
          interval_ms_q <=
            sdpc_pkg::IntervalW'(cfg_data_i[sdpc_pkg::MinutesW-1:0]) *
            sdpc_pkg::IntervalW'(sdpc_pkg::MS_PER_MIN);
        end
        sdpc_pkg::REG_FLUSH_DURATION_S: begin
          duration_ms_q <=
            sdpc_pkg::DurationW'(cfg_data_i[sdpc_pkg::SecondsW-1:0]) *
            sdpc_pkg::DurationW'(sdpc_pkg::MS_PER_S);
        end
        sdpc_pkg::REG_MANUAL_MODE: manual_mode_q <= cfg_data_i[0];
        sdpc_pkg::REG_MANUAL_PUMP: manual_pump_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input register
  logic                 s1_valid_q, s1_valid_d;
  logic [TW-1:0]        air_raw_q, spa_raw_q, panel_raw_q;
  logic [NW-1:0]        now_q;
  logic                 out_valid_q, out_valid_d;
  logic                 out_free, adv, in_take;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign adv        = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      air_raw_q   <= air_temp_i;
      spa_raw_q   <= spa_temp_i;
      panel_raw_q <= panel_temp_i;
      now_q       <= now_ms_i;
    end
  end

  // decision
  logic                 pump_state_q, pump_state_d;
  logic                 flush_active_q, flush_active_d;
  logic                 flushed_before_q, flushed_before_d;
  logic [NW-1:0]        flush_start_q, flush_start_d;
  logic [NW-1:0]        last_flush_q, last_flush_d;
  logic                 cut_d;

  logic signed [TW-1:0] air, spa, panel;
  logic signed [TW+1:0] diff, thr_s, stop_s;
  logic                 warm, heat, flush_eval, flush_start, fa_mid;
  logic [NW-1:0]        fs_mid, since_last, since_start;

  always_comb begin
    air        = sdpc_pkg::reading(air_raw_q);
    spa        = sdpc_pkg::reading(spa_raw_q);
    panel      = sdpc_pkg::reading(panel_raw_q);
    diff       = (TW+2)'(panel) - (TW+2)'(spa);
    thr_s      = signed'((TW+2)'(thr_q));
    stop_s     = thr_s - signed'((TW+2)'(hys_q));
    warm       = air >= min_air_q;
    heat       = (warm && (spa < max_spa_q) && (diff >= thr_s)) ||
                 (pump_state_q && warm && (diff >= stop_s));
    flush_eval = !heat && warm && (interval_ms_q != '0);
    since_last = now_q - last_flush_q;
    flush_start = flush_eval && !flush_active_q &&
                  (!flushed_before_q || (since_last >= NW'(interval_ms_q)));
    fa_mid      = flush_active_q || flush_start;
    fs_mid      = flush_start ? now_q : flush_start_q;
    since_start = now_q - fs_mid;

    pump_state_d     = pump_state_q;
    flush_active_d   = flush_active_q;
    flushed_before_d = flushed_before_q;
    flush_start_d    = flush_start_q;
    last_flush_d     = last_flush_q;
    cut_d            = 1'b0;

    if (manual_mode_q) begin
      pump_state_d = manual_pump_q;
    end else begin
      pump_state_d  = heat;
      flush_start_d = fs_mid;
      if (flush_eval) begin
        flush_active_d = fa_mid;
        if (fa_mid) begin
          if (since_start < NW'(duration_ms_q)) begin
            pump_state_d = 1'b1;
          end else begin
            flush_active_d   = 1'b0;
            last_flush_d     = now_q;
            flushed_before_d = 1'b1;
          end
        end
      end else if (heat) begin
        flush_active_d   = 1'b0;
        last_flush_d     = now_q;
        flushed_before_d = 1'b1;
      end
      if (spa >= max_spa_q) begin
        pump_state_d = 1'b0;
        cut_d        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pump_state_q     <= 1'b0;
      flush_active_q   <= 1'b0;
      flushed_before_q <= 1'b0;
      flush_start_q    <= '0;
      last_flush_q     <= '0;
    end else if (adv) begin
      pump_state_q     <= pump_state_d;
      flush_active_q   <= flush_active_d;
      flushed_before_q <= flushed_before_d;
      flush_start_q    <= flush_start_d;
      last_flush_q     <= last_flush_d;
    end
  end

  // result register
  logic pump_on_q, pump_changed_q, flushing_q, safety_cut_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pump_on_q      <= pump_state_d;
      pump_changed_q <= pump_state_d ^ pump_state_q;
      flushing_q     <= flush_active_d;
      safety_cut_q   <= cut_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pump_on_o      = pump_on_q;
  assign pump_changed_o = pump_changed_q;
  assign flushing_o     = flushing_q;
  assign safety_cut_o   = safety_cut_q;

  `SDPC_ASSERT(a_cut_forces_off, out_valid_q && safety_cut_q |-> !pump_on_q, "cut with pump on")
  `SDPC_ASSERT(a_state_matches_out, out_valid_q |-> pump_state_q == pump_on_q, "pump state mismatch")
  `SDPC_ASSERT(a_stall_needs_item, in_stall_o |-> s1_valid_q && out_valid_q, "stall without item")

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;

  typedef struct {
    logic signed [sdpc_pkg::TempW-1:0] air;
    logic signed [sdpc_pkg::TempW-1:0] spa;
    logic signed [sdpc_pkg::TempW-1:0] panel;
    logic [sdpc_pkg::TimeW-1:0]        now;
  } tick_t;

  typedef struct packed {
    logic pump_on;
    logic pump_changed;
    logic flushing;
    logic safety_cut;
  } decision_t;

  typedef struct {
    logic signed [sdpc_pkg::TempW-1:0] min_air;
    logic signed [sdpc_pkg::TempW-1:0] max_spa;
    logic [sdpc_pkg::DiffW-1:0]        thresh;
    logic [sdpc_pkg::DiffW-1:0]        hyst;
    logic [sdpc_pkg::MinutesW-1:0]     interval;
    logic [sdpc_pkg::SecondsW-1:0]     duration;
    logic                              manual_mode;
    logic                              manual_pump;
  } settings_t;

  function automatic settings_t mk_settings(int ma, int ms, int th, int hy, int iv, int du,
                                            bit mm, bit mp);
    settings_t s;
    s.min_air     = sdpc_pkg::TempW'(ma);
    s.max_spa     = sdpc_pkg::TempW'(ms);
    s.thresh      = sdpc_pkg::DiffW'(th);
    s.hyst        = sdpc_pkg::DiffW'(hy);
    s.interval    = sdpc_pkg::MinutesW'(iv);
    s.duration    = sdpc_pkg::SecondsW'(du);
    s.manual_mode = mm;
    s.manual_pump = mp;
    return s;
  endfunction

  class pump_decision_board;
    settings_t   cfg;
    logic        pump_state, flush_active, flushed_before;
    logic [31:0] flush_start, last_flush;
    decision_t   pending_decisions[$];
    int          n_ticks, n_checked, n_err, n_on, n_flush, n_cut;

    function new();
      cfg            = mk_settings(160, 608, 64, 16, 0, 60, 1'b0, 1'b0);
      pump_state     = 1'b0;
      flush_active   = 1'b0;
      flushed_before = 1'b0;
      flush_start    = '0;
      last_flush     = '0;
    endfunction

    function int probe(logic signed [sdpc_pkg::TempW-1:0] raw);
      return (raw == sdpc_pkg::DISCONNECTED_CODE) ? 0 : int'(raw);
    endfunction

    function decision_t decide(tick_t t);
      int          air, spa, panel, diff, thr, stop_lvl;
      logic        warm, nxt, cut, prev;
      logic [31:0] interval_ms, duration_ms, elapsed;
      decision_t   d;
      air   = probe(t.air);
      spa   = probe(t.spa);
      panel = probe(t.panel);
      prev  = pump_state;
      cut   = 1'b0;
      if (cfg.manual_mode) begin
        nxt = cfg.manual_pump;
      end else begin
        diff     = panel - spa;
        thr      = int'(cfg.thresh);
        warm     = air >= int'(cfg.min_air);
        stop_lvl = thr - int'(cfg.hyst);
        nxt = warm && (spa < int'(cfg.max_spa)) && (diff >= thr);
        if (pump_state && warm && diff >= stop_lvl) nxt = 1'b1;
        if (!nxt && warm && cfg.interval != 0) begin
          interval_ms = 32'(cfg.interval) * sdpc_pkg::MS_PER_MIN;
          duration_ms = 32'(cfg.duration) * sdpc_pkg::MS_PER_S;
          elapsed     = t.now - last_flush;
          if (!flush_active && (!flushed_before || elapsed >= interval_ms)) begin
            flush_active = 1'b1;
            flush_start  = t.now;
          end
          if (flush_active) begin
            elapsed = t.now - flush_start;
            if (elapsed < duration_ms) begin
              nxt = 1'b1;
            end else begin
              flush_active   = 1'b0;
              last_flush     = t.now;
              flushed_before = 1'b1;
            end
          end
        end else if (nxt) begin
          flush_active   = 1'b0;
          last_flush     = t.now;
          flushed_before = 1'b1;
        end
        if (spa >= int'(cfg.max_spa)) begin
          nxt = 1'b0;
          cut = 1'b1;
        end
      end
      pump_state     = nxt;
      d.pump_on      = nxt;
      d.pump_changed = nxt != prev;
      d.flushing     = flush_active;
      d.safety_cut   = cut;
      return d;
    endfunction

    function void note_tick(tick_t t);
      pending_decisions.push_back(decide(t));
      n_ticks++;
    endfunction

    task report(string msg);
      if (n_err < 40) $display("MISMATCH: %s", msg);
      n_err++;
    endtask

    task check_decision(decision_t got);
      decision_t want;
      n_checked++;
      n_on    += got.pump_on;
      n_flush += got.flushing;
      n_cut   += got.safety_cut;
      if (pending_decisions.size() == 0) begin
        report($sformatf("result %0d arrived with no tick pending", n_checked));
        return;
      end
      want = pending_decisions.pop_front();
      if (got.pump_on !== want.pump_on)
        report($sformatf("result %0d pump_on got %b want %b", n_checked,
                         got.pump_on, want.pump_on));
      if (got.pump_changed !== want.pump_changed)
        report($sformatf("result %0d pump_changed got %b want %b", n_checked,
                         got.pump_changed, want.pump_changed));
      if (got.flushing !== want.flushing)
        report($sformatf("result %0d flushing got %b want %b", n_checked,
                         got.flushing, want.flushing));
      if (got.safety_cut !== want.safety_cut)
        report($sformatf("result %0d safety_cut got %b want %b", n_checked,
                         got.safety_cut, want.safety_cut));
    endtask
  endclass

  logic                              clk_i, rst_ni;
  logic                              cfg_we_i;
  logic [sdpc_pkg::CfgIdxW-1:0]      cfg_idx_i;
  logic [sdpc_pkg::CfgDataW-1:0]     cfg_data_i;
  logic                              in_valid_i, in_stall_o;
  logic signed [sdpc_pkg::TempW-1:0] air_temp_i, spa_temp_i, panel_temp_i;
  logic [sdpc_pkg::TimeW-1:0]        now_ms_i;
  logic                              out_valid_o, out_stall_i;
  logic                              pump_on_o, pump_changed_o, flushing_o, safety_cut_o;

  pump_decision_board board = new();
  bit                 quiet;
  logic [31:0]        t_now;
  int                 n_settings;

  solar_differential_pump_control DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic signed [sdpc_pkg::TempW-1:0] clamp12(int v);
    if (v > 2047) return 12'sd2047;
    if (v < -2048) return -12'sd2048;
    return sdpc_pkg::TempW'(v);
  endfunction

  function automatic tick_t mk(int a, int s, int p, logic [31:0] n);
    tick_t t;
    t.air   = clamp12(a);
    t.spa   = clamp12(s);
    t.panel = clamp12(p);
    t.now   = n;
    return t;
  endfunction

  // Mostly values around the configured switching points, some noise.
  function automatic tick_t gen_tick(settings_t s);
    int    sel, a, spa, d;
    tick_t t;
    sel = $urandom_range(0, 99);
    a   = int'(s.min_air) + int'($urandom_range(0, 20)) - 6;
    spa = int'(s.max_spa) - int'($urandom_range(0, 150)) + 3;
    d   = int'(s.thresh) - int'(s.hyst) - 10 + int'($urandom_range(0, 32'(s.hyst) + 20));
    t   = mk(a, spa, spa + d, t_now);
    if (sel < 8) begin
      t.air   = sdpc_pkg::TempW'($urandom());
      t.spa   = sdpc_pkg::TempW'($urandom());
      t.panel = sdpc_pkg::TempW'($urandom());
    end else if (sel < 14) begin
      case ($urandom_range(0, 2))
        0:       t.air   = sdpc_pkg::DISCONNECTED_CODE;
        1:       t.spa   = sdpc_pkg::DISCONNECTED_CODE;
        default: t.panel = sdpc_pkg::DISCONNECTED_CODE;
      endcase
    end
    return t;
  endfunction

  task automatic offer_tick(tick_t t);
    in_valid_i   <= 1'b1;
    air_temp_i   <= t.air;
    spa_temp_i   <= t.spa;
    panel_temp_i <= t.panel;
    now_ms_i     <= t.now;
    do @(posedge clk_i); while (in_stall_o);
    board.note_tick(t);
  endtask

  task automatic feed(tick_t t);
    if (!quiet && $urandom_range(0, 99) < 5) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    offer_tick(t);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.pending_decisions.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_reg(logic [sdpc_pkg::CfgIdxW-1:0] idx,
                             logic [sdpc_pkg::CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic write_settings(settings_t s);
    program_reg(sdpc_pkg::REG_MIN_AIR_TEMP, s.min_air);
    program_reg(sdpc_pkg::REG_MAX_SPA_TEMP, s.max_spa);
    program_reg(sdpc_pkg::REG_DIFF_THRESHOLD, sdpc_pkg::CfgDataW'(s.thresh));
    program_reg(sdpc_pkg::REG_HYSTERESIS, sdpc_pkg::CfgDataW'(s.hyst));
    program_reg(sdpc_pkg::REG_FLUSH_INTERVAL_MIN, sdpc_pkg::CfgDataW'(s.interval));
    program_reg(sdpc_pkg::REG_FLUSH_DURATION_S, s.duration);
    program_reg(sdpc_pkg::REG_MANUAL_MODE, sdpc_pkg::CfgDataW'(s.manual_mode));
    program_reg(sdpc_pkg::REG_MANUAL_PUMP, sdpc_pkg::CfgDataW'(s.manual_pump));
    cfg_we_i <= 1'b0;
    board.cfg = s;
    n_settings++;
  endtask

  task automatic run_phase(settings_t s, int n, bit no_idle, bit drain_mid);
    int unsigned tstep;
    int          sel;
    settle();
    write_settings(s);
    quiet = no_idle;
    tstep = (32'(s.duration) * sdpc_pkg::MS_PER_S +
             32'(s.interval) * sdpc_pkg::MS_PER_MIN) / 12 + 500;
    for (int i = 0; i < n; i++) begin
      if (drain_mid && i == n / 2) settle();
      sel = $urandom_range(0, 99);
      if (sel < 5) t_now = $urandom();
      else if (sel < 20) t_now += $urandom_range(0, 50);
      else t_now += $urandom_range(0, tstep);
      feed(gen_tick(s));
    end
    quiet = 1'b0;
  endtask

  // Result side: check, then pick the stall for the next cycle.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i)
        board.check_decision('{pump_on: pump_on_o, pump_changed: pump_changed_o,
                               flushing: flushing_o, safety_cut: safety_cut_o});
      if (!hold_done && board.n_checked >= 350) begin
        hold_done = 1'b1;
        hold_left = 120;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !quiet && ($urandom_range(0, 99) < 10);
      end
    end
  end

  initial begin
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    air_temp_i   = '0;
    spa_temp_i   = '0;
    panel_temp_i = '0;
    now_ms_i     = '0;
    out_stall_i  = 1'b0;
    rst_ni       = 1'b0;
    quiet        = 1'b0;
    t_now        = '0;
    n_settings   = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: extremes, hysteresis band, safety cut, disconnected probes
    feed(mk(2047, -2048, 2047, 32'h0000_0000));
    feed(mk(-2048, 0, 2047, 32'hFFFF_FFFF));
    feed(mk(160, 607, 671, 100));
    feed(mk(160, 600, 648, 200));
    feed(mk(160, 600, 647, 300));
    feed(mk(160, 600, 663, 400));
    feed(mk(200, 608, 2047, 500));
    feed(mk(2047, 2047, 2047, 600));
    feed(mk(-2032, 0, 2047, 700));
    feed(mk(200, -2032, 64, 800));
    feed(mk(200, -64, -2032, 900));
    feed(mk(159, 0, 2047, 1000));

    // flush: first flush, end, interval, heating restart, cut, time wrap
    settle();
    write_settings(mk_settings(160, 608, 64, 16, 1, 2, 1'b0, 1'b0));
    feed(mk(200, 100, 100, 1000));
    feed(mk(200, 100, 100, 2999));
    feed(mk(200, 100, 100, 3000));
    feed(mk(200, 100, 100, 30000));
    feed(mk(200, 100, 100, 63000));
    feed(mk(200, 100, 200, 63500));
    feed(mk(200, 100, 100, 64000));
    feed(mk(200, 608, 100, 130000));
    feed(mk(200, 100, 100, 32'hFFFF_F000));
    feed(mk(200, 100, 100, 32'h0000_0800));

    // manual mode ignores the spa limit
    settle();
    write_settings(mk_settings(160, 608, 64, 16, 1, 2, 1'b1, 1'b1));
    feed(mk(200, 2047, 100, 5000));
    feed(mk(-2048, 100, 100, 6000));
    settle();
    write_settings(mk_settings(160, 608, 64, 16, 1, 2, 1'b1, 1'b0));
    feed(mk(200, 100, 2047, 7000));

    run_phase(mk_settings(160, 608, 64, 16, 1, 5, 1'b0, 1'b0), 115, 1'b0, 1'b0);
    run_phase(mk_settings(-2048, 2047, 0, 0, 2, 10, 1'b0, 1'b0), 115, 1'b1, 1'b0);
    run_phase(mk_settings(2047, -2048, 2047, 2047, 1440, 3600, 1'b0, 1'b0), 115, 1'b0, 1'b0);
    run_phase(mk_settings($urandom_range(0, 300) - 100, $urandom_range(200, 900),
                          $urandom_range(0, 200), $urandom_range(0, 80), 1, 0, 1'b0, 1'b0),
              115, 1'b0, 1'b1);
    run_phase(mk_settings(160, 608, 64, 16, 1, 5, 1'b1, 1'b1), 115, 1'b0, 1'b0);
    run_phase(mk_settings(100, 500, $urandom_range(0, 40), $urandom_range(41, 120), 2047, 4095,
                          1'b0, 1'b0), 115, 1'b0, 1'b0);
    run_phase(mk_settings($urandom_range(0, 400) - 100, $urandom_range(200, 900),
                          $urandom_range(0, 200), $urandom_range(0, 80),
                          $urandom_range(1, 3), $urandom_range(0, 30), 1'b0, 1'b0),
              115, 1'b0, 1'b0);
    run_phase(mk_settings($urandom_range(0, 400) - 100, $urandom_range(200, 900),
                          $urandom_range(0, 200), $urandom_range(0, 80),
                          0, $urandom_range(0, 30), 1'b0, 1'b0), 115, 1'b0, 1'b0);
    t_now = 32'hFFFF_0000;
    run_phase(mk_settings(160, 608, 64, 16, 1, 3, 1'b0, 1'b0), 115, 1'b0, 1'b0);

    in_valid_i <= 1'b0;
    while (board.pending_decisions.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("Covered %0d ticks under %0d register settings, %0d results checked",
             board.n_ticks, n_settings, board.n_checked);
    $display("Pump on in %0d results, flushing in %0d, safety cut in %0d",
             board.n_on, board.n_flush, board.n_cut);
    if (board.n_err == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
